// ===== rtl/spmq_pkg.sv =====
// spmq_pkg: shared types and constants for the strict priority message queue
// no dependencies
package spmq_pkg;

  localparam int unsigned StatusW = 3;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_UNINIT  = 3'd2,
    ST_SIZE    = 3'd3,
    ST_FULL    = 3'd4,
    ST_EMPTY   = 3'd5,
    ST_MISSING = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_PRESENT  = 3'd1,
    REG_MAXSIZE  = 3'd2,
    REG_DEPTH    = 3'd3,
    REG_REQSIZE  = 3'd4,
    REG_FALLBACK = 3'd5
  } reg_e;

  // controller to datapath commands
  typedef struct packed {
    logic decide;   // capture request and evaluate decision
    logic commit;   // apply state update and load result
  } spmq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic busy;
  } spmq_stat_t;

endpackage

// ===== rtl/spmq_ram.sv =====
// spmq_ram: generic single-port-write, single-read RAM with registered read
// no dependencies
module spmq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/spmq_ctrl.sv =====
// spmq_ctrl: request sequencer, a decide step then a commit step per request
// depends on spmq_pkg
module spmq_ctrl import spmq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  output spmq_cmd_t cmd_o
);
  typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_COMMIT} state_e;
  state_e state_q;

  // accept when idle and the output slot is free or draining
  assign in_ready_o   = (state_q == S_IDLE) && (!out_valid_i || out_ready_i);
  assign cmd_o.decide = in_ready_o && in_valid_i;
  assign cmd_o.commit = (state_q == S_COMMIT);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:   if (cmd_o.decide) state_q <= S_DECIDE;
        S_DECIDE: state_q <= S_COMMIT;
        S_COMMIT: state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/spmq_dp.sv =====
// spmq_dp: queue state, decision logic, message memories and result register
// depends on spmq_pkg and spmq_ram
module spmq_dp import spmq_pkg::*; #(
  parameter int unsigned NumPrio  = 8,
  parameter int unsigned QDepth   = 16,
  parameter int unsigned PayBytes = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spmq_cmd_t       cmd_i,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [63:0]     cfg_data_i,
  input  logic            mode_i,
  input  logic [7:0]      prio_in_i,
  input  logic [63:0]     payload_in_i,
  input  logic [3:0]      length_in_i,
  input  logic [3:0]      capacity_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [2:0]      status_o,
  output logic [63:0]     payload_out_o,
  output logic [3:0]      length_out_o,
  output logic [2:0]      prio_out_o,
  output logic [7:0]      total_o,
  output logic [4:0]      peak_o
);
  localparam int unsigned PW  = (NumPrio > 1) ? $clog2(NumPrio) : 1;
  localparam int unsigned QW  = $clog2(QDepth);
  localparam int unsigned FW  = $clog2(QDepth + 1);
  localparam int unsigned AW  = $clog2(NumPrio * QDepth);
  localparam int unsigned TW  = $clog2(NumPrio * QDepth + 1);
  localparam int unsigned PayW = 8 * PayBytes;

  // configuration registers
  logic [7:0]  enable_q, present_q;
  logic [63:0] maxsize_q, depth_q;
  logic        reqsize_q;
  logic [2:0]  fallback_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 8'h01;
      present_q  <= 8'h01;
      maxsize_q  <= 64'h0808080808080808;
      depth_q    <= 64'h1010101010101010;
      reqsize_q  <= 1'b0;
      fallback_q <= 3'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE:   enable_q   <= cfg_data_i[7:0];
        REG_PRESENT:  present_q  <= cfg_data_i[7:0];
        REG_MAXSIZE:  maxsize_q  <= cfg_data_i;
        REG_DEPTH:    depth_q    <= cfg_data_i;
        REG_REQSIZE:  reqsize_q  <= cfg_data_i[0];
        REG_FALLBACK: fallback_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // per-priority queue state
  logic [QW-1:0] head_q [NumPrio];
  logic [FW-1:0] fill_q [NumPrio];
  logic [FW-1:0] hw_q   [NumPrio];
  logic [TW-1:0] total_q;

  // captured request
  logic          mode_q;
  logic [7:0]    req_q;
  logic [PayW-1:0] pay_q;
  logic [3:0]    len_q, cap_q;

  // decision, valid in the decide-to-commit cycle
  logic [NumPrio-1:0] pres_v, en_v;
  logic [PW-1:0] recv_p, send_p;
  logic          recv_hit, do_push, do_pop;
  logic [2:0]    st_d, pr_d;
  logic [7:0]    msz, dsz;
  logic [FW-1:0] cap_eff;
  logic          fb_ok;

  assign pres_v = present_q[NumPrio-1:0];
  assign en_v   = enable_q[NumPrio-1:0];

  // highest servable priority
  always_comb begin
    recv_hit = 1'b0;
    recv_p   = '0;
    for (int i = 0; i < NumPrio; i++) begin
      if (en_v[i] && pres_v[i] && fill_q[i] != '0) begin
        recv_hit = 1'b1;
        recv_p   = PW'(i);
      end
    end
  end

  // send path decision
  always_comb begin
    fb_ok  = (32'(fallback_q) < NumPrio) && present_q[fallback_q];
    send_p = PW'(req_q);
    st_d   = ST_OK;
    pr_d   = 3'd0;
    do_push = 1'b0;
    do_pop  = 1'b0;
    msz = '0;
    dsz = '0;
    cap_eff = '0;
    if (!mode_q && 32'(req_q) >= NumPrio) begin
      st_d = ST_INVALID;
    end else if (pres_v == '0) begin
      st_d = ST_UNINIT;
    end else if (!mode_q) begin
      if (!present_q[req_q[2:0]] && (reqsize_q || !fb_ok)) begin
        st_d = ST_MISSING;
        pr_d = req_q[2:0];
      end else begin
        if (!present_q[req_q[2:0]]) send_p = PW'(fallback_q);
        pr_d = 3'(send_p);
        msz  = maxsize_q[8*send_p +: 8];
        dsz  = depth_q[8*send_p +: 8];
        cap_eff = (32'(dsz) > QDepth) ? FW'(QDepth) : FW'(dsz);
        if (len_q == 4'd0 || 32'(len_q) > PayBytes || {4'd0, len_q} > msz) begin
          st_d = ST_SIZE;
        end else if (fill_q[send_p] >= cap_eff) begin
          st_d = ST_FULL;
        end else begin
          do_push = 1'b1;
        end
      end
    end else if (recv_hit) begin
      pr_d   = 3'(recv_p);
      do_pop = 1'b1;
    end else begin
      st_d = ST_EMPTY;
    end
  end

  // memory addressing: read head at decide, write tail at commit
  logic [QW-1:0] tail;
  logic [QW:0]   tail_sum;
  logic [AW-1:0] raddr, waddr;
  logic [PayW-1:0] wmask, rpay;
  logic [3:0]    rlen;
  logic [QW-1:0] rd_head;

  assign tail_sum = {1'b0, head_q[send_p]} + (QW+1)'(fill_q[send_p]);
  assign tail = (32'(tail_sum) >= QDepth) ? QW'(32'(tail_sum) - QDepth) : QW'(tail_sum);
  assign waddr = AW'(32'(send_p) * QDepth + 32'(tail));
  assign rd_head = head_q[recv_p];
  assign raddr = AW'(32'(recv_p) * QDepth + 32'(rd_head));

  always_comb begin
    wmask = '0;
    for (int b = 0; b < PayBytes; b++) if (b < 32'(len_q)) wmask[8*b +: 8] = 8'hff;
  end

  spmq_ram #(.Width(PayW), .Depth(NumPrio * QDepth)) u_pay_ram (
    .clk_i, .we_i(cmd_i.commit && do_push), .waddr_i(waddr),
    .wdata_i(pay_q & wmask), .raddr_i(raddr), .rdata_o(rpay)
  );
  spmq_ram #(.Width(4), .Depth(NumPrio * QDepth)) u_len_ram (
    .clk_i, .we_i(cmd_i.commit && do_push), .waddr_i(waddr),
    .wdata_i(len_q), .raddr_i(raddr), .rdata_o(rlen)
  );

  // receive truncation
  logic [3:0] cap_c, dlen;
  logic [PayW-1:0] rmask;
  assign cap_c = (32'(cap_q) > PayBytes) ? 4'(PayBytes) : cap_q;
  assign dlen  = (rlen > cap_c) ? cap_c : rlen;
  always_comb begin
    rmask = '0;
    for (int b = 0; b < PayBytes; b++) if (b < 32'(dlen)) rmask[8*b +: 8] = 8'hff;
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      mode_q <= mode_i;
      req_q  <= prio_in_i;
      pay_q  <= payload_in_i[PayW-1:0];
      len_q  <= length_in_i;
      cap_q  <= capacity_i;
    end
  end

  // queue state update at commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPrio; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
        hw_q[i]   <= '0;
      end
      total_q <= '0;
    end else if (cmd_i.commit) begin
      if (do_push) begin
        fill_q[send_p] <= fill_q[send_p] + FW'(1);
        if (fill_q[send_p] + FW'(1) > hw_q[send_p]) hw_q[send_p] <= fill_q[send_p] + FW'(1);
        total_q <= total_q + TW'(1);
      end else if (do_pop) begin
        fill_q[recv_p] <= fill_q[recv_p] - FW'(1);
        head_q[recv_p] <= (32'(rd_head) == QDepth - 1) ? '0 : rd_head + QW'(1);
        if (total_q != '0) total_q <= total_q - TW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_o      <= st_d;
      prio_out_o    <= pr_d;
      payload_out_o <= do_pop ? 64'(rpay & rmask) : 64'd0;
      length_out_o  <= do_pop ? dlen : 4'd0;
    end
  end

  // totals and peak from live state, saturated to the result fields
  logic [FW-1:0] peak_max;
  always_comb begin
    peak_max = '0;
    for (int i = 0; i < NumPrio; i++) if (hw_q[i] > peak_max) peak_max = hw_q[i];
  end
  assign total_o = (32'(total_q) > 255) ? 8'hff : 8'(total_q);
  assign peak_o  = (32'(peak_max) > 31) ? 5'd31 : 5'(peak_max);
endmodule

// ===== rtl/strict_priority_message_queue_top.sv =====
// strict_priority_message_queue_top: stream wrapper joining controller and datapath
// depends on spmq_pkg, spmq_ctrl, spmq_dp, spmq_ram
//
//  channel | dir | contents
//  s_axis  | in  | tuser mode; tdata prio_in, payload_in, length_in, capacity
//  m_axis  | out | tdata status, payload_out, length_out, prio_out, total_waiting, peak_fill
//  cfg     | in  | write enable, register index, 64-bit data
//
// each request is accepted in idle, then passes a decide step that reads the head entry from the
// registered-read message memory and a commit step that updates pointers and loads the result.
// reset clears all counters and pointers; message memories are not cleared.
// the input stalls while a result waits and m_axis_tready is low.
module strict_priority_message_queue_top import spmq_pkg::*; #(
  parameter int unsigned NUM_PRIORITIES = 8,
  parameter int unsigned QUEUE_DEPTH    = 16,
  parameter int unsigned PAYLOAD_BYTES  = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,  // prio_in[7:0], payload_in[71:8], length_in[75:72], capacity[79:76]
  input  logic         s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata,  // status, payload_out, length_out, prio_out, total_waiting, peak_fill
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i
);
  spmq_cmd_t cmd;
  logic [2:0]  st, pr;
  logic [63:0] pay;
  logic [3:0]  len;
  logic [7:0]  total;
  logic [4:0]  peak;

  spmq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_i(m_axis_tvalid), .out_ready_i(m_axis_tready), .cmd_o(cmd)
  );

  spmq_dp #(.NumPrio(NUM_PRIORITIES), .QDepth(QUEUE_DEPTH), .PayBytes(PAYLOAD_BYTES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .mode_i(s_axis_tuser), .prio_in_i(s_axis_tdata[7:0]), .payload_in_i(s_axis_tdata[71:8]),
    .length_in_i(s_axis_tdata[75:72]), .capacity_i(s_axis_tdata[79:76]),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .status_o(st), .payload_out_o(pay), .length_out_o(len), .prio_out_o(pr),
    .total_o(total), .peak_o(peak)
  );

  // totals and peak as of the step, taken from live state (stable while result waits)
  assign m_axis_tdata = {1'b0, peak, total, pr, len, pay, st};
endmodule

// ===== verif/tb.sv =====
// tb: self-checking bench for strict_priority_message_queue_top
// depends on spmq_pkg and the rtl under rtl/
module tb;
  import spmq_pkg::*;

  localparam int NP = 8;
  localparam int QD = 16;
  localparam int PB = 8;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata = '0;  // prio_in, payload_in, length_in, capacity
  logic         s_axis_tuser = 1'b0; // mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;  // status, payload_out, length_out, prio_out, total, peak
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [63:0]  cfg_data_i = '0;

  typedef struct packed {
    logic [4:0]  peak;
    logic [7:0]  total;
    logic [2:0]  prio;
    logic [3:0]  len;
    logic [63:0] payload;
    status_e     status;
  } answer_t;

  typedef struct {
    logic        mode;
    logic [7:0]  prio;
    logic [63:0] payload;
    logic [3:0]  len;
    logic [3:0]  cap;
    logic        typed;   // row carries a typed-in answer
    status_e     status;
    logic [2:0]  rprio;
  } row_t;

  strict_priority_message_queue_top dut (.*);

  always #10 clk_i = ~clk_i;

  // shadow queue state
  logic [7:0]  en_mask, pr_mask, req_sz;
  logic [2:0]  fb_prio;
  logic [63:0] max_tab, dep_tab;
  logic [63:0] msg_pay [NP][QD];
  logic [3:0]  msg_len [NP][QD];
  int          head [NP], fill [NP], hwm [NP], held;

  answer_t answers_due[$];
  int      errors = 0;
  int      mismatches = 0;

  function automatic logic [63:0] byte_mask(int n);
    return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 1);
  endfunction

  function automatic answer_t queue_step(logic mode, logic [7:0] rq, logic [63:0] pay,
                                         logic [3:0] ln, logic [3:0] cp);
    answer_t a;
    int p, cap, slot, pk, c, l;
    a = '0;
    a.status = ST_OK;
    if (!mode && rq >= NP) a.status = ST_INVALID;
    else if (pr_mask == 0) a.status = ST_UNINIT;
    else if (!mode) begin
      p = rq;
      if (!pr_mask[p]) begin
        if (req_sz[0] || !pr_mask[fb_prio]) begin
          a.status = ST_MISSING;
          p = rq;
        end else p = fb_prio;
      end
      a.prio = p[2:0];
      cap = dep_tab[8*p +: 8];
      if (cap > QD) cap = QD;
      if (a.status != ST_OK) ;
      else if (ln == 0 || ln > PB || ln > max_tab[8*p +: 8]) a.status = ST_SIZE;
      else if (fill[p] >= cap) a.status = ST_FULL;
      else begin
        slot = (head[p] + fill[p]) % QD;
        msg_pay[p][slot] = pay & byte_mask(ln);
        msg_len[p][slot] = ln;
        fill[p]++;
        held++;
        if (fill[p] > hwm[p]) hwm[p] = fill[p];
      end
    end else begin
      c = (cp > PB) ? PB : cp;
      a.status = ST_EMPTY;
      for (p = NP - 1; p >= 0; p--) begin
        if (en_mask[p] && pr_mask[p] && fill[p] != 0) begin
          l = msg_len[p][head[p]];
          if (l > c) l = c;
          a.status = ST_OK;
          a.payload = msg_pay[p][head[p]] & byte_mask(l);
          a.len = l[3:0];
          a.prio = p[2:0];
          head[p] = (head[p] + 1) % QD;
          fill[p]--;
          if (held > 0) held--;
          break;
        end
      end
    end
    pk = 0;
    for (int i = 0; i < NP; i++) if (hwm[i] > pk) pk = hwm[i];
    a.total = (held > 255) ? 8'd255 : held[7:0];
    a.peak = (pk > 31) ? 5'd31 : pk[4:0];
    return a;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    answer_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[86:0];
      if (answers_due.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = answers_due.pop_front();
        if (got !== want) begin
          errors++;
          if (mismatches++ < 10)
            $display({"mismatch: exp st=%0d pay=%h len=%0d pr=%0d tot=%0d pk=%0d,",
                      " got st=%0d pay=%h len=%0d pr=%0d tot=%0d pk=%0d"},
                     want.status, want.payload, want.len, want.prio, want.total, want.peak,
                     got.status, got.payload, got.len, got.prio, got.total, got.peak);
        end
      end
    end
  end

  // receiver stall pattern, sometimes fully open
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk_i);
      phase++;
      if ((phase / 300) % 3 == 2) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // register write once nothing is in flight
  task automatic cfg_write(reg_e idx, logic [63:0] val);
    while (answers_due.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ENABLE:   en_mask = val[7:0];
      REG_PRESENT:  pr_mask = val[7:0];
      REG_MAXSIZE:  max_tab = val;
      REG_DEPTH:    dep_tab = val;
      REG_REQSIZE:  req_sz = {7'd0, val[0]};
      REG_FALLBACK: fb_prio = val[2:0];
      default: ;
    endcase
  endtask

  int burst = 0;

  // send one request, gaps in bursts
  task automatic push_request(logic mode, logic [7:0] rq, logic [63:0] pay,
                              logic [3:0] ln, logic [3:0] cp);
    @(posedge clk_i);
    if (burst == 0) begin
      burst = $urandom_range(1, 20);
      repeat ($urandom_range(0, 4)) @(posedge clk_i);
    end
    burst--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {cp, ln, pay, rq};
    do @(posedge clk_i); while (!s_axis_tready);
    answers_due.push_back(queue_step(mode, rq, pay, ln, cp));
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic settle;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic random_item(int skew);
    logic mode;
    logic [7:0] rq;
    mode = ($urandom_range(0, 99) < skew);
    rq = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, NP - 1));
    push_request(mode, rq, {$urandom, $urandom}, 4'($urandom_range(0, 15) == 0 ?
                 $urandom : $urandom_range(1, 8)), 4'($urandom));
  endtask

  row_t rows[$];

  function automatic row_t mk(logic m, logic [7:0] p, logic [63:0] d, logic [3:0] l,
                              logic [3:0] c, logic t, status_e s, logic [2:0] rp);
    row_t r;
    r = '{m, p, d, l, c, t, s, rp};
    return r;
  endfunction

  initial begin
    answer_t a;
    en_mask = 8'd1; pr_mask = 8'd1; req_sz = 0; fb_prio = 0;
    max_tab = 64'h0808080808080808; dep_tab = 64'h1010101010101010;
    for (int i = 0; i < NP; i++) begin head[i] = 0; fill[i] = 0; hwm[i] = 0; end
    held = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table at reset settings
    rows.push_back(mk(1, 0, 0, 1, 8, 1, ST_EMPTY, 0));
    rows.push_back(mk(0, 8'd8, '1, 8, 8, 1, ST_INVALID, 0));
    rows.push_back(mk(0, 8'hff, '1, 8, 8, 1, ST_INVALID, 0));
    rows.push_back(mk(0, 0, '1, 0, 8, 1, ST_SIZE, 0));
    rows.push_back(mk(0, 0, '1, 4'd9, 8, 1, ST_SIZE, 0));
    rows.push_back(mk(0, 0, '1, 4'd15, 8, 1, ST_SIZE, 0));
    rows.push_back(mk(0, 0, '1, 8, 8, 1, ST_OK, 0));
    rows.push_back(mk(0, 7, 64'h0123456789abcdef, 3, 8, 1, ST_OK, 0));
    rows.push_back(mk(0, 3, 64'h0, 1, 8, 1, ST_OK, 0));
    rows.push_back(mk(1, 0, 0, 0, 4'd15, 0, ST_OK, 0));
    rows.push_back(mk(1, 0, 0, 0, 4'd0, 0, ST_OK, 0));
    rows.push_back(mk(1, 0, 0, 0, 4'd2, 0, ST_OK, 0));
    rows.push_back(mk(1, 0, 0, 0, 4'd8, 1, ST_EMPTY, 0));
    foreach (rows[i]) begin
      push_request(rows[i].mode, rows[i].prio, rows[i].payload, rows[i].len, rows[i].cap);
      a = answers_due[$];
      if (rows[i].typed && (a.status != rows[i].status || a.prio != rows[i].rprio)) begin
        errors++;
        $display("table row %0d disagrees with predictor", i);
      end
    end
    settle();

    // uninitialized, missing priority and fallback, then size and depth limits
    cfg_write(REG_PRESENT, 64'h0);
    push_request(0, 2, 64'h55, 1, 1);
    push_request(1, 0, 0, 1, 1);
    settle();
    cfg_write(REG_PRESENT, 64'h0f);
    cfg_write(REG_FALLBACK, 64'd7);
    push_request(0, 6, 64'h1, 1, 1);
    cfg_write(REG_FALLBACK, 64'd2);
    push_request(0, 6, 64'h1, 1, 1);
    cfg_write(REG_REQSIZE, 64'd1);
    push_request(0, 6, 64'h1, 1, 1);
    cfg_write(REG_MAXSIZE, 64'h0001020304050607);
    push_request(0, 3, '1, 5, 1);
    cfg_write(REG_DEPTH, 64'h00ff020304050607);
    push_request(0, 0, '1, 1, 1);
    settle();

    // random phases over several settings
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_ENABLE, 64'hff); cfg_write(REG_PRESENT, 64'hff);
          cfg_write(REG_MAXSIZE, 64'h0808080808080808);
          cfg_write(REG_DEPTH, 64'h1010101010101010);
          cfg_write(REG_REQSIZE, 0); cfg_write(REG_FALLBACK, 0);
        end
        1: begin
          cfg_write(REG_DEPTH, 64'hff00020304100110);
          cfg_write(REG_MAXSIZE, 64'hff00080706050403);
        end
        9: begin
          cfg_write(REG_ENABLE, 64'h0); cfg_write(REG_PRESENT, 64'hff);
        end
        default: begin
          cfg_write(REG_ENABLE, {$urandom, $urandom});
          cfg_write(REG_PRESENT, {$urandom, $urandom} | 64'd1);
          cfg_write(REG_MAXSIZE, {$urandom, $urandom} | 64'h0404040404040404);
          cfg_write(REG_DEPTH, {$urandom, $urandom});
          cfg_write(REG_REQSIZE, $urandom_range(0, 1));
          cfg_write(REG_FALLBACK, $urandom_range(0, 7));
        end
      endcase
      // fill-heavy then drain-heavy
      repeat (50) random_item(25);
      repeat (50) random_item(70);
      settle();
    end

    settle();
    if (errors == 0) $display("** strict_priority_message_queue_top: PASSED **");
    else $display("** strict_priority_message_queue_top: FAILED **");
    $finish;
  end

  // timeout
  initial begin
    #20000000;
    $display("** strict_priority_message_queue_top: FAILED **");
    $finish;
  end

endmodule
